// File: src/cdt_pkg.sv
// Shared types and constants for the minutes:seconds countdown timer.
package cdt_pkg;

	localparam int unsigned MIN_W = 7;
	localparam int unsigned SEC_W = 6;

	localparam logic [MIN_W-1:0] MAX_MIN       = 7'd99;
	localparam logic [SEC_W-1:0] MAX_SEC       = 6'd59;
	localparam logic [MIN_W-1:0] DEFAULT_START = 7'd25;

	typedef enum logic {
		CMD_TICK = 1'b0,
		CMD_KEY  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		KEY_OK    = 2'd0,
		KEY_RIGHT = 2'd1,
		KEY_LEFT  = 2'd2,
		KEY_OTHER = 2'd3
	} key_t;

	typedef enum logic [1:0] {
		PRESS_SHORT      = 2'd0,
		PRESS_LONG_START = 2'd1,
		PRESS_DOUBLE     = 2'd2,
		PRESS_LONG_HELD  = 2'd3
	} press_t;

	typedef enum logic [1:0] {
		ST_READY    = 2'd0,
		ST_COUNTING = 2'd1,
		ST_FINISHED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MODE_DISPLAY = 2'd0,
		MODE_MIN     = 2'd1,
		MODE_SEC     = 2'd2
	} mode_t;

	typedef struct packed {
		cmd_t   cmd;
		key_t   key;
		press_t kind;
	} item_t;

	typedef struct packed {
		logic [MIN_W-1:0] minutes;
		logic [SEC_W-1:0] seconds;
		status_t          status;
		mode_t            mode;
		logic             alarm;
	} result_t;

endpackage

// File: src/cdt_in_stage.sv
// Input register stage: captures one key or tick transfer per cycle while in_ready is high.
module cdt_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  cdt_pkg::item_t  item,
	input  logic            advance,
	output logic            valid_s1,
	output cdt_pkg::item_t  item_s1
);

	logic valid_q;

	// accept when the stage is empty or its item moves on this cycle
	assign in_ready = !valid_q || advance;
	assign valid_s1 = valid_q;

	// hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// capture the payload on a transfer
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item;
		end
	end

endmodule

// File: src/cdt_core.sv
// Timer state registers and the per-item next-state logic.
module cdt_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  cdt_pkg::item_t               item_s1,
	input  logic                         cfg_we,
	input  logic [cdt_pkg::MIN_W-1:0]    cfg_wdata,
	output cdt_pkg::result_t             result
);

	logic [cdt_pkg::MIN_W-1:0] minutes_q, saved_min_q, minutes_d, saved_min_d, cfg_min;
	logic [cdt_pkg::SEC_W-1:0] seconds_q, saved_sec_q, seconds_d, saved_sec_d;
	cdt_pkg::status_t          status_q, status_d;
	cdt_pkg::mode_t            mode_q, mode_d;
	logic                      alarm_d;

	// saturate the written start value
	assign cfg_min = (cfg_wdata > cdt_pkg::MAX_MIN) ? cdt_pkg::MAX_MIN : cfg_wdata;

	// work out the state after the current item
	always_comb begin
		minutes_d   = minutes_q;
		seconds_d   = seconds_q;
		status_d    = status_q;
		mode_d      = mode_q;
		saved_min_d = saved_min_q;
		saved_sec_d = saved_sec_q;
		alarm_d     = 1'b0;
		if (item_s1.cmd == cdt_pkg::CMD_TICK) begin
			if (status_q == cdt_pkg::ST_COUNTING) begin
				if (seconds_q != '0) begin
					seconds_d = seconds_q - 6'd1;
				end else if (minutes_q != '0) begin
					minutes_d = minutes_q - 7'd1;
					seconds_d = cdt_pkg::MAX_SEC;
				end else begin
					status_d = cdt_pkg::ST_FINISHED;
					alarm_d  = 1'b1;
				end
			end
		end else begin
			unique case (item_s1.key)
				cdt_pkg::KEY_OK: begin
					if (item_s1.kind == cdt_pkg::PRESS_SHORT) begin
						unique case (mode_q)
							cdt_pkg::MODE_DISPLAY: begin
								if (status_q == cdt_pkg::ST_COUNTING) begin
									status_d = cdt_pkg::ST_READY;
								end else if (status_q == cdt_pkg::ST_READY) begin
									saved_min_d = minutes_q;
									saved_sec_d = seconds_q;
									status_d    = cdt_pkg::ST_COUNTING;
								end else begin
									// finished (or the unused code): restore saved time
									minutes_d = saved_min_q;
									seconds_d = saved_sec_q;
									status_d  = cdt_pkg::ST_READY;
								end
							end
							cdt_pkg::MODE_MIN: mode_d = cdt_pkg::MODE_DISPLAY;
							default:           mode_d = cdt_pkg::MODE_MIN;
						endcase
					end else if (item_s1.kind == cdt_pkg::PRESS_LONG_START) begin
						if (mode_q == cdt_pkg::MODE_DISPLAY) begin
							mode_d   = cdt_pkg::MODE_SEC;
							status_d = cdt_pkg::ST_READY;
						end
					end
				end
				cdt_pkg::KEY_RIGHT: begin
					if (mode_q == cdt_pkg::MODE_MIN) begin
						minutes_d = (minutes_q >= cdt_pkg::MAX_MIN) ? '0 : minutes_q + 7'd1;
					end else if (mode_q == cdt_pkg::MODE_SEC) begin
						seconds_d = (seconds_q >= cdt_pkg::MAX_SEC) ? '0 : seconds_q + 6'd1;
					end
				end
				cdt_pkg::KEY_LEFT: begin
					if (mode_q == cdt_pkg::MODE_MIN) begin
						minutes_d = (minutes_q == '0) ? cdt_pkg::MAX_MIN : minutes_q - 7'd1;
					end else if (mode_q == cdt_pkg::MODE_SEC) begin
						seconds_d = (seconds_q == '0) ? cdt_pkg::MAX_SEC : seconds_q - 6'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign result = '{minutes: minutes_d, seconds: seconds_d, status: status_d,
		mode: mode_d, alarm: alarm_d};

	// commit the item, or load a new start time from the register port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			minutes_q   <= cdt_pkg::DEFAULT_START;
			seconds_q   <= '0;
			status_q    <= cdt_pkg::ST_READY;
			mode_q      <= cdt_pkg::MODE_DISPLAY;
			saved_min_q <= cdt_pkg::DEFAULT_START;
			saved_sec_q <= '0;
		end else if (cfg_we) begin
			minutes_q   <= cfg_min;
			saved_min_q <= cfg_min;
		end else if (advance) begin
			minutes_q   <= minutes_d;
			seconds_q   <= seconds_d;
			status_q    <= status_d;
			mode_q      <= mode_d;
			saved_min_q <= saved_min_d;
			saved_sec_q <= saved_sec_d;
		end
	end

endmodule

// File: src/cdt_out_stage.sv
// Result register: holds one result until the receiver takes it.
module cdt_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  cdt_pkg::result_t  result,
	input  logic              out_ready,
	output logic              advance,
	output logic              valid_s2,
	output cdt_pkg::result_t  res_s2
);

	// move the item on when the result register is free or drains now
	assign advance = valid_s1 && (!valid_s2 || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// load the result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

endmodule

// File: src/countdown_timer_with_keys.sv
// Top level of the minutes:seconds countdown timer driven by keys and ticks.
//
// Input channel (in_valid/in_ready): one item per transfer, either a
// one-second tick (cmd 0) or a key event (cmd 1) with key and press_kind.
// Output channel (out_valid/out_ready): exactly one result per item, giving
// the time, run status, edit mode and the alarm pulse of the finishing tick.
// cfg_we/cfg_wdata load a new start time in minutes (saturated at 99); it
// sets the current and saved minutes. The user must write it only while idle;
// the block itself does not enforce this. An item transferred enters the input
// register, then moves into the result register, where out_valid rises, once
// that register is free or drains.
// Throughput: one item per cycle while the receiver does not stall, set by
// the combinational next-state logic in front of the state registers.
// Reset: time 25:00, status ready, display mode, both stages empty.
// Receiver stall: the result register holds; the input register still takes
// one more item, after which in_ready stays low until out_ready returns.
module countdown_timer_with_keys (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       cmd,
	input  logic [1:0]                 key,
	input  logic [1:0]                 press_kind,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [cdt_pkg::MIN_W-1:0]  minutes_now,
	output logic [cdt_pkg::SEC_W-1:0]  seconds_now,
	output logic [1:0]                 run_status,
	output logic [1:0]                 edit_mode,
	output logic                       alarm,
	input  logic                       cfg_we,
	input  logic [cdt_pkg::MIN_W-1:0]  cfg_wdata
);

	cdt_pkg::item_t   item, item_s1;
	cdt_pkg::result_t result, res_s2;
	logic             valid_s1, advance;

	assign item = '{cmd: cdt_pkg::cmd_t'(cmd), key: cdt_pkg::key_t'(key),
		kind: cdt_pkg::press_t'(press_kind)};

	cdt_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item     (item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	cdt_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item_s1   (item_s1),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.result    (result)
	);

	cdt_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.result    (result),
		.out_ready (out_ready),
		.advance   (advance),
		.valid_s2  (out_valid),
		.res_s2    (res_s2)
	);

	// drive the result fields
	assign minutes_now = res_s2.minutes;
	assign seconds_now = res_s2.seconds;
	assign run_status  = res_s2.status;
	assign edit_mode   = res_s2.mode;
	assign alarm       = res_s2.alarm;

	// the alarm only comes with a finished count at zero
	a_alarm_finished: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && alarm |-> run_status == cdt_pkg::ST_FINISHED
			&& minutes_now == '0 && seconds_now == '0)
		else $error("alarm without a finished count at 00:00");

	// seconds stay within one minute
	a_sec_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> seconds_now <= cdt_pkg::MAX_SEC)
		else $error("seconds out of range");

	// input stalls only when both stages are full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid && !out_ready)
		else $error("input stalled with room in the pipeline");

	// a waiting item is moved on as soon as the result register frees
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_ready |-> advance)
		else $error("item held although the result register drains");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the minutes:seconds countdown timer.
`timescale 1ns / 1ps

module testbench;
	import cdt_pkg::*;

	// Timer state as the checker tracks it
	typedef struct {
		logic [MIN_W-1:0] mins;
		logic [SEC_W-1:0] secs;
		status_t          status;
		mode_t            mode;
		logic [MIN_W-1:0] saved_mins;
		logic [SEC_W-1:0] saved_secs;
	} timer_state_t;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 in_valid   = 1'b0;
	logic                 in_ready;
	logic                 cmd        = 1'b0;
	logic [1:0]           key        = 2'd0;
	logic [1:0]           press_kind = 2'd0;
	logic                 out_valid;
	logic                 out_ready  = 1'b0;
	logic [MIN_W-1:0]     minutes_now;
	logic [SEC_W-1:0]     seconds_now;
	logic [1:0]           run_status;
	logic [1:0]           edit_mode;
	logic                 alarm;
	logic                 cfg_we     = 1'b0;
	logic [MIN_W-1:0]     cfg_wdata  = '0;

	item_t        queued_events[$];
	result_t      awaited_readouts[$];
	timer_state_t timer_model;
	timer_state_t plan_state;
	int           errors = 0;
	int           queued_count = 0;

	// Sender burst and receiver stall pacing
	int burst_left = 1;
	int gap_left = 0;
	bit seg_on = 1'b0;
	int seg_left = 0;

	countdown_timer_with_keys i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.key        (key),
		.press_kind (press_kind),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.minutes_now(minutes_now),
		.seconds_now(seconds_now),
		.run_status (run_status),
		.edit_mode  (edit_mode),
		.alarm      (alarm),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Advance the timer by one event and return the readout it produces
	function automatic result_t apply_item(inout timer_state_t st, input item_t ev);
		result_t r;
		r.alarm = 1'b0;
		if (ev.cmd == CMD_TICK) begin
			if (st.status == ST_COUNTING) begin
				if (st.secs != 0) begin
					st.secs = st.secs - 1'b1;
				end else if (st.mins != 0) begin
					st.mins = st.mins - 1'b1;
					st.secs = MAX_SEC;
				end else begin
					st.status = ST_FINISHED;
					r.alarm = 1'b1;
				end
			end
		end else begin
			case (ev.key)
				KEY_OK: begin
					if (ev.kind == PRESS_SHORT) begin
						if (st.mode == MODE_DISPLAY) begin
							if (st.status == ST_COUNTING) begin
								st.status = ST_READY;
							end else if (st.status == ST_READY) begin
								st.saved_mins = st.mins;
								st.saved_secs = st.secs;
								st.status = ST_COUNTING;
							end else begin
								st.mins = st.saved_mins;
								st.secs = st.saved_secs;
								st.status = ST_READY;
							end
						end else if (st.mode == MODE_MIN) begin
							st.mode = MODE_DISPLAY;
						end else begin
							st.mode = MODE_MIN;
						end
					end else if (ev.kind == PRESS_LONG_START && st.mode == MODE_DISPLAY) begin
						st.mode = MODE_SEC;
						st.status = ST_READY;
					end
				end
				KEY_RIGHT: begin
					if (st.mode == MODE_MIN)
						st.mins = (st.mins >= MAX_MIN) ? '0 : st.mins + 1'b1;
					else if (st.mode == MODE_SEC)
						st.secs = (st.secs >= MAX_SEC) ? '0 : st.secs + 1'b1;
				end
				KEY_LEFT: begin
					if (st.mode == MODE_MIN)
						st.mins = (st.mins == 0) ? MAX_MIN : st.mins - 1'b1;
					else if (st.mode == MODE_SEC)
						st.secs = (st.secs == 0) ? MAX_SEC : st.secs - 1'b1;
				end
				default: ;
			endcase
		end
		r.minutes = st.mins;
		r.seconds = st.secs;
		r.status = st.status;
		r.mode = st.mode;
		return r;
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// Queue one event and track where it leaves the timer
	task automatic send(cmd_t c, key_t k, press_t p);
		item_t ev;
		result_t unused;
		ev.cmd = c;
		ev.key = k;
		ev.kind = p;
		unused = apply_item(plan_state, ev);
		queued_events.push_back(ev);
		queued_count++;
	endtask

	task automatic send_tick();
		send(CMD_TICK, key_t'($urandom_range(0, 3)), press_t'($urandom_range(0, 3)));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (queued_events.size() != 0 || in_valid || awaited_readouts.size() != 0)
			@(negedge clk);
	endtask

	// Load a new start time while idle and mirror it in the checker
	task automatic load_start(logic [MIN_W-1:0] value);
		logic [MIN_W-1:0] sat;
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sat = (value > MAX_MIN) ? MAX_MIN : value;
		timer_model.mins = sat;
		timer_model.saved_mins = sat;
		plan_state = timer_model;
	endtask

	// Random scenarios: edit-and-run sequences most often, also stop/resume, ticks with a long press, and noise
	task automatic plan_random(int count);
		int base;
		int r;
		int remaining;
		int ticks;
		base = queued_count;
		while (queued_count - base < count) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				while (plan_state.mode != MODE_DISPLAY) send(CMD_KEY, KEY_OK, PRESS_SHORT);
				send(CMD_KEY, KEY_OK, PRESS_LONG_START);
				repeat ($urandom_range(0, 4))
					send(CMD_KEY, $urandom_range(0, 1) ? KEY_RIGHT : KEY_LEFT,
						press_t'($urandom_range(0, 3)));
				send(CMD_KEY, KEY_OK, PRESS_SHORT);
				// steer the minutes toward zero so the countdown can finish
				repeat (3)
					if (plan_state.mins != 0)
						send(CMD_KEY, (plan_state.mins >= 50) ? KEY_RIGHT : KEY_LEFT,
							press_t'($urandom_range(0, 3)));
				send(CMD_KEY, KEY_OK, PRESS_SHORT);
				send(CMD_KEY, KEY_OK, PRESS_SHORT);
				remaining = int'(plan_state.mins) * 60 + int'(plan_state.secs);
				if (remaining <= 150 && $urandom_range(0, 3) != 0)
					ticks = remaining + 1 + $urandom_range(0, 2);
				else
					ticks = $urandom_range(1, 30);
				repeat (ticks) send_tick();
				if (plan_state.status == ST_FINISHED && $urandom_range(0, 1))
					send(CMD_KEY, KEY_OK, PRESS_SHORT);
			end else if (r < 65) begin
				while (plan_state.mode != MODE_DISPLAY) send(CMD_KEY, KEY_OK, PRESS_SHORT);
				while (plan_state.status != ST_COUNTING) send(CMD_KEY, KEY_OK, PRESS_SHORT);
				repeat ($urandom_range(1, 20)) send_tick();
				send(CMD_KEY, KEY_OK, PRESS_SHORT);
				repeat ($urandom_range(0, 3)) send_tick();
				send(CMD_KEY, KEY_OK, PRESS_SHORT);
				repeat ($urandom_range(1, 10)) send_tick();
			end else if (r < 80) begin
				repeat ($urandom_range(0, 5)) send_tick();
				send(CMD_KEY, KEY_OK, PRESS_LONG_START);
			end else begin
				repeat ($urandom_range(5, 15))
					send(cmd_t'($urandom_range(0, 1)), key_t'($urandom_range(0, 3)),
						press_t'($urandom_range(0, 3)));
			end
		end
	endtask

	// Drive queued events in bursts with random gaps
	always @(posedge clk or negedge arst_n) begin : drive
		item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (queued_events.size() != 0) begin
				nxt = queued_events.pop_front();
				in_valid <= 1'b1;
				cmd <= nxt.cmd;
				key <= nxt.key;
				press_kind <= nxt.kind;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the result channel in runs of random length
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (seg_left == 0) begin
				seg_on = ($urandom_range(0, 2) != 0);
				seg_left = seg_on ? $urandom_range(1, 40) : $urandom_range(1, 8);
			end
			seg_left--;
			out_ready <= seg_on;
		end
	end

	// Predict on each input transfer, check on each result transfer
	always @(posedge clk) begin : watch
		item_t seen;
		result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				seen = item_t'({cmd, key, press_kind});
				awaited_readouts.push_back(apply_item(timer_model, seen));
			end
			if (out_valid && out_ready) begin
				if (awaited_readouts.size() == 0) begin
					$error("result with no event pending: %0d:%0d", minutes_now, seconds_now);
					errors++;
				end else begin
					want = awaited_readouts.pop_front();
					check_field("minutes_now", want.minutes, minutes_now);
					check_field("seconds_now", want.seconds, seconds_now);
					check_field("run_status", want.status, run_status);
					check_field("edit_mode", want.mode, edit_mode);
					check_field("alarm", want.alarm, alarm);
				end
			end
		end
	end

	initial begin
		logic [MIN_W-1:0] starts [8];
		starts = '{7'd99, 7'd127, 7'd1, 7'd100, 7'd2, 7'd0, 7'd0, 7'd1};
		starts[6] = MIN_W'($urandom_range(0, 127));
		timer_model.mins = DEFAULT_START;
		timer_model.secs = '0;
		timer_model.status = ST_READY;
		timer_model.mode = MODE_DISPLAY;
		timer_model.saved_mins = DEFAULT_START;
		timer_model.saved_secs = '0;
		plan_state = timer_model;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Ignored events, edit wrap, start, borrow, long press while counting, stop
		send(CMD_TICK, KEY_OK, PRESS_SHORT);
		send(CMD_KEY, KEY_OTHER, PRESS_SHORT);
		send(CMD_KEY, KEY_OK, PRESS_DOUBLE);
		send(CMD_KEY, KEY_OK, PRESS_LONG_HELD);
		send(CMD_KEY, KEY_RIGHT, PRESS_SHORT);
		send(CMD_KEY, KEY_OK, PRESS_LONG_START);
		send(CMD_KEY, KEY_LEFT, PRESS_SHORT);
		send(CMD_KEY, KEY_RIGHT, PRESS_SHORT);
		send(CMD_KEY, KEY_OK, PRESS_LONG_START);
		send(CMD_KEY, KEY_OK, PRESS_SHORT);
		send(CMD_KEY, KEY_LEFT, PRESS_LONG_HELD);
		send(CMD_KEY, KEY_OK, PRESS_SHORT);
		send(CMD_KEY, KEY_OK, PRESS_SHORT);
		send(CMD_TICK, KEY_OTHER, PRESS_LONG_HELD);
		send(CMD_KEY, KEY_OK, PRESS_LONG_START);
		send(CMD_KEY, KEY_OK, PRESS_SHORT);
		send(CMD_KEY, KEY_OK, PRESS_SHORT);
		send(CMD_KEY, KEY_OK, PRESS_SHORT);
		send(CMD_KEY, KEY_OK, PRESS_SHORT);
		wait_idle();

		// Zero start: minute wrap both ways, stop and resume, finish at 00:00, long press
		load_start('0);
		send(CMD_KEY, KEY_OK, PRESS_LONG_START);
		send(CMD_KEY, KEY_RIGHT, PRESS_SHORT);
		send(CMD_KEY, KEY_OK, PRESS_SHORT);
		send(CMD_KEY, KEY_LEFT, PRESS_SHORT);
		send(CMD_KEY, KEY_RIGHT, PRESS_DOUBLE);
		send(CMD_KEY, KEY_OK, PRESS_SHORT);
		send(CMD_KEY, KEY_OK, PRESS_SHORT);
		send(CMD_TICK, KEY_LEFT, PRESS_DOUBLE);
		send(CMD_KEY, KEY_OK, PRESS_SHORT);
		send(CMD_KEY, KEY_OK, PRESS_SHORT);
		send(CMD_TICK, KEY_RIGHT, PRESS_LONG_START);
		send(CMD_KEY, KEY_OK, PRESS_LONG_START);
		wait_idle();

		// Random phases, each loading its start time from the starts table
		for (int p = 0; p < 8; p++) begin
			load_start(starts[p]);
			if (p == 2) begin
				plan_random(70);
				wait_idle();
				plan_random(70);
			end else begin
				plan_random(135);
			end
			wait_idle();
		end

		repeat (5) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
